// ----- sv/snr_pkg.sv -----
// Shared constants, codes and control types of the socket name registry.
package snr_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int NAME_BYTES    = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {
		REQ_ADD        = 3'd0,
		REQ_LOOKUP     = 3'd1,
		REQ_DEL_NAME   = 3'd2,
		REQ_DEL_HANDLE = 3'd3,
		REQ_DEL_OWNER  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic last;
		logic no_scan;
	} ctl_sts_t;

endpackage

// ----- sv/snr_ctrl.sv -----
// Controller state machine of the socket name registry.
module snr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  snr_pkg::ctl_sts_t sts,
	output snr_pkg::ctl_cmd_t cmd
);
	import snr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.last || sts.no_scan) state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_DONE: begin
				cmd.commit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ----- sv/snr_datapath.sv -----
// Datapath of the socket name registry: entry table, scan trackers and result registers.
module snr_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  snr_pkg::ctl_cmd_t cmd,
	output snr_pkg::ctl_sts_t sts,
	input  logic [2:0]        req_type,
	input  logic [63:0]       name_low,
	input  logic [63:0]       name_high,
	input  logic [4:0]        name_length,
	input  logic [15:0]       owner_id,
	input  logic [3:0]        entry_handle,
	output logic              done,
	output logic [1:0]        status,
	output logic [15:0]       found_owner,
	output logic [3:0]        new_handle,
	output logic [4:0]        removed_count
);
	import snr_pkg::*;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [127:0]             s_name_q  [TABLE_ENTRIES];
	logic [4:0]               s_len_q   [TABLE_ENTRIES];
	logic [15:0]              s_owner_q [TABLE_ENTRIES];

	req_t         req_q;
	logic [127:0] name_q;
	logic [4:0]   len_q;
	logic [15:0]  owner_q;
	logic [3:0]   handle_q;
	logic [IDX_W-1:0] k_q;

	logic             match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [15:0]      match_owner_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic [CNT_W-1:0] removed_q;

	logic             done_q;
	status_t          status_q;
	logic [15:0]      found_owner_q;
	logic [3:0]       new_handle_q;
	logic [4:0]       removed_count_q;

	logic [4:0]       eff_len;
	logic [127:0]     name_full;
	logic [127:0]     name_m;
	logic             hit;
	logic             handle_ok;
	logic [IDX_W-1:0] hidx;

	assign eff_len   = (name_length > 5'(NAME_BYTES)) ? 5'(NAME_BYTES) : name_length;
	assign name_full = {name_high, name_low};

	always_comb begin
		name_m = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < eff_len) name_m[8*i +: 8] = name_full[8*i +: 8];
		end
	end

	assign hit = valid_q[k_q] && (s_len_q[k_q] == len_q) && (s_name_q[k_q] == name_q);
	assign hidx      = IDX_W'(handle_q);
	assign handle_ok = ({5'd0, handle_q} < 9'(TABLE_ENTRIES)) && valid_q[hidx];

	assign sts.last    = (k_q == IDX_W'(TABLE_ENTRIES - 1));
	assign sts.no_scan = (req_q == REQ_DEL_HANDLE) || !((req_q == REQ_ADD)
		|| (req_q == REQ_LOOKUP) || (req_q == REQ_DEL_NAME) || (req_q == REQ_DEL_OWNER));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_t'(req_type);
			name_q   <= name_m;
			len_q    <= eff_len;
			owner_q  <= owner_id;
			handle_q <= entry_handle;
		end
		if (cmd.scan && hit && !match_found_q) begin
			match_idx_q   <= k_q;
			match_owner_q <= s_owner_q[k_q];
		end
		if (cmd.scan && !valid_q[k_q] && !free_found_q) begin
			free_idx_q <= k_q;
		end
		if (cmd.commit && (req_q == REQ_ADD) && !match_found_q && free_found_q) begin
			s_name_q[free_idx_q]  <= name_q;
			s_len_q[free_idx_q]   <= len_q;
			s_owner_q[free_idx_q] <= owner_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			k_q           <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			removed_q     <= '0;
		end else begin
			if (cmd.load) begin
				k_q           <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				removed_q     <= '0;
			end
			if (cmd.scan) begin
				k_q <= k_q + IDX_W'(1);
				if (hit) match_found_q <= 1'b1;
				if (!valid_q[k_q]) free_found_q <= 1'b1;
				if ((req_q == REQ_DEL_OWNER) && valid_q[k_q] && (s_owner_q[k_q] == owner_q)) begin
					valid_q[k_q] <= 1'b0;
					removed_q    <= removed_q + CNT_W'(1);
				end
			end
			if (cmd.commit) begin
				case (req_q)
					REQ_ADD: begin
						if (!match_found_q && free_found_q) valid_q[free_idx_q] <= 1'b1;
					end
					REQ_DEL_NAME: begin
						if (match_found_q) valid_q[match_idx_q] <= 1'b0;
					end
					REQ_DEL_HANDLE: begin
						if (handle_ok) valid_q[hidx] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q        <= ST_OK;
			found_owner_q   <= '0;
			new_handle_q    <= '0;
			removed_count_q <= '0;
			case (req_q)
				REQ_ADD: begin
					if (match_found_q) begin
						status_q <= ST_DUP;
					end else if (free_found_q) begin
						new_handle_q <= 4'(free_idx_q);
					end else begin
						status_q <= ST_FULL;
					end
				end
				REQ_LOOKUP: begin
					if (match_found_q) found_owner_q <= match_owner_q;
					else status_q <= ST_NOTFOUND;
				end
				REQ_DEL_NAME: begin
					if (match_found_q) removed_count_q <= 5'd1;
					else status_q <= ST_NOTFOUND;
				end
				REQ_DEL_HANDLE: begin
					if (handle_ok) removed_count_q <= 5'd1;
					else status_q <= ST_NOTFOUND;
				end
				REQ_DEL_OWNER: begin
					removed_count_q <= 5'(removed_q);
				end
				default: begin
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found_owner   = found_owner_q;
	assign new_handle    = new_handle_q;
	assign removed_count = removed_count_q;

endmodule

// ----- sv/socket_name_registry.sv -----
// Top level of the socket name registry.
// Usage:
//   Drive req_type, name_low, name_high, name_length, owner_id and entry_handle
//   and raise start; the request transfers at the rising edge where start is
//   high and busy is low. busy stays high until the result has been produced.
//   The result (status, found_owner, new_handle, removed_count) is marked by
//   done for a single cycle, then held to the next; the receiver cannot stall.
// Timing:
//   Add, lookup and both delete-by-name/owner requests walk the table one
//   entry per cycle through the datapath compare unit; the scan state is
//   followed by the commit state, which registers the result and done.
//   Delete by handle and unknown codes skip the walk. busy blocks a new
//   request until done; one can transfer in the cycle where done is high.
// Reset:
//   arst_n clears all valid bits at once, so the table is empty; no sweep.
module socket_name_registry (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] name_low,
	input  logic [63:0] name_high,
	input  logic [4:0]  name_length,
	input  logic [15:0] owner_id,
	input  logic [3:0]  entry_handle,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] found_owner,
	output logic [3:0]  new_handle,
	output logic [4:0]  removed_count
);
	import snr_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	snr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	snr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.name_low      (name_low),
		.name_high     (name_high),
		.name_length   (name_length),
		.owner_id      (owner_id),
		.entry_handle  (entry_handle),
		.done          (done),
		.status        (status),
		.found_owner   (found_owner),
		.new_handle    (new_handle),
		.removed_count (removed_count)
	);

endmodule

// ----- test/snr_checker.sv -----
// Checker for the socket name registry: mirrors the table, predicts every result and compares.
module snr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] name_low,
	input  logic [63:0] name_high,
	input  logic [4:0]  name_length,
	input  logic [15:0] owner_id,
	input  logic [3:0]  entry_handle,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [15:0] found_owner,
	input  logic [3:0]  new_handle,
	input  logic [4:0]  removed_count,
	output int unsigned errors,
	output int unsigned pending,
	output int unsigned checked
);
	import snr_pkg::*;

	typedef struct packed {
		status_t          status;
		logic [15:0]      owner;
		logic [IDX_W-1:0] handle;
		logic [CNT_W-1:0] removed;
	} registry_result_t;

	bit          slot_used  [TABLE_ENTRIES];
	bit   [63:0] slot_lo    [TABLE_ENTRIES];
	bit   [63:0] slot_hi    [TABLE_ENTRIES];
	int          slot_len   [TABLE_ENTRIES];
	bit   [15:0] slot_owner [TABLE_ENTRIES];

	registry_result_t expected_results[$];

	function automatic logic [63:0] low_bytes(int n);
		if (n <= 0)
			return '0;
		if (n >= 8)
			return '1;
		return (64'd1 << (8 * n)) - 64'd1;
	endfunction

	function automatic int find_name(logic [63:0] lo, logic [63:0] hi, int n);
		for (int k = 0; k < TABLE_ENTRIES; k++)
			if (slot_used[k] && slot_len[k] == n && slot_lo[k] == lo && slot_hi[k] == hi)
				return k;
		return -1;
	endfunction

	function automatic int first_free_slot();
		for (int k = 0; k < TABLE_ENTRIES; k++)
			if (!slot_used[k])
				return k;
		return -1;
	endfunction

	task automatic registry_apply(input logic [2:0] code, input logic [63:0] lo_in,
			input logic [63:0] hi_in, input logic [4:0] len_in, input logic [15:0] own,
			input logic [3:0] hnd, output registry_result_t res);
		int          n;
		int          slot;
		logic [63:0] lo;
		logic [63:0] hi;
		n = (len_in > NAME_BYTES) ? NAME_BYTES : int'(len_in);
		lo = lo_in & low_bytes(n);
		hi = hi_in & low_bytes(n - 8);
		res = '0;
		case (code)
			REQ_ADD: begin
				slot = find_name(lo, hi, n);
				if (slot >= 0) begin
					res.status = ST_DUP;
				end else begin
					slot = first_free_slot();
					if (slot < 0) begin
						res.status = ST_FULL;
					end else begin
						slot_used[slot]  = 1'b1;
						slot_lo[slot]    = lo;
						slot_hi[slot]    = hi;
						slot_len[slot]   = n;
						slot_owner[slot] = own;
						res.handle       = IDX_W'(slot);
					end
				end
			end
			REQ_LOOKUP: begin
				slot = find_name(lo, hi, n);
				if (slot >= 0)
					res.owner = slot_owner[slot];
				else
					res.status = ST_NOTFOUND;
			end
			REQ_DEL_NAME: begin
				slot = find_name(lo, hi, n);
				if (slot >= 0) begin
					slot_used[slot] = 1'b0;
					res.removed     = CNT_W'(1);
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			REQ_DEL_HANDLE: begin
				if (int'(hnd) < TABLE_ENTRIES && slot_used[hnd]) begin
					slot_used[hnd] = 1'b0;
					res.removed    = CNT_W'(1);
				end else begin
					res.status = ST_NOTFOUND;
				end
			end
			REQ_DEL_OWNER: begin
				for (int k = 0; k < TABLE_ENTRIES; k++)
					if (slot_used[k] && slot_owner[k] == own) begin
						slot_used[k] = 1'b0;
						res.removed  = res.removed + CNT_W'(1);
					end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		registry_result_t got;
		registry_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < TABLE_ENTRIES; k++)
				slot_used[k] = 1'b0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (done) begin
				got = {status, found_owner, new_handle, removed_count};
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with no request outstanding: %s %0d %h %0d %0d",
							$time, "status/owner/handle/removed", status,
							found_owner, new_handle, removed_count);
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch: expected status %0d owner %h %s %0d %0d",
								$time, want.status, want.owner, "handle/removed",
								want.handle, want.removed);
							$display("%0t:           got status %0d owner %h %s %0d %0d",
								$time, got.status, got.owner, "handle/removed",
								got.handle, got.removed);
						end
					end
				end
			end
			if (start && !busy) begin
				registry_apply(req_type, name_low, name_high, name_length, owner_id,
					entry_handle, want);
				expected_results.push_back(want);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ----- test/tb_socket_name_registry.sv -----
// Testbench top for the socket name registry: directed and random requests, verdict.
module tb_socket_name_registry;
	import snr_pkg::*;

	localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
	localparam int         RANDOM_ITEMS      = 1300;
	localparam int         NAME_POOL         = 24;
	localparam int         OWNER_POOL        = 4;
	localparam logic [15:0] FILL_OWNER       = 16'h8000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  req_type = '0;
	logic [63:0] name_low = '0;
	logic [63:0] name_high = '0;
	logic [4:0]  name_length = '0;
	logic [15:0] owner_id = '0;
	logic [3:0]  entry_handle = '0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] found_owner;
	logic [3:0]  new_handle;
	logic [4:0]  removed_count;

	int unsigned errors;
	int unsigned pending;
	int unsigned checked;

	bit          quiet;
	int unsigned sent_by_code [8];
	logic [63:0] pool_lo [NAME_POOL];
	logic [63:0] pool_hi [NAME_POOL];
	int          pool_len [NAME_POOL];
	logic [15:0] owner_set [OWNER_POOL];

	socket_name_registry dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.name_low      (name_low),
		.name_high     (name_high),
		.name_length   (name_length),
		.owner_id      (owner_id),
		.entry_handle  (entry_handle),
		.done          (done),
		.status        (status),
		.found_owner   (found_owner),
		.new_handle    (new_handle),
		.removed_count (removed_count)
	);

	snr_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.name_low      (name_low),
		.name_high     (name_high),
		.name_length   (name_length),
		.owner_id      (owner_id),
		.entry_handle  (entry_handle),
		.done          (done),
		.status        (status),
		.found_owner   (found_owner),
		.new_handle    (new_handle),
		.removed_count (removed_count),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_request(input logic [2:0] code, input logic [63:0] lo,
			input logic [63:0] hi, input logic [4:0] len, input logic [15:0] own,
			input logic [3:0] hnd);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			if (quiet || $urandom_range(99) >= 7) begin
				req_type     <= code;
				name_low     <= lo;
				name_high    <= hi;
				name_length  <= len;
				owner_id     <= own;
				entry_handle <= hnd;
				start        <= 1'b1;
			end else begin
				start <= 1'b0;
			end
			@(posedge clk);
			taken = start && !busy;
		end
		sent_by_code[code]++;
	endtask

	task automatic random_request(input bit fill_phase);
		int          pick;
		int          k;
		int          len;
		logic [4:0]  drive_len;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [15:0] own;
		logic [2:0]  code;
		pick = $urandom_range(99);
		k = $urandom_range(NAME_POOL - 1);
		len = pool_len[k];
		lo = pool_lo[k] ^ ({$urandom, $urandom} << (8 * len));
		hi = pool_hi[k] ^ ((len > 8) ? ({$urandom, $urandom} << (8 * (len - 8)))
			: {$urandom, $urandom});
		drive_len = (len == NAME_BYTES && $urandom_range(1)) ?
			5'($urandom_range(31, NAME_BYTES)) : 5'(len);
		own = owner_set[$urandom_range(OWNER_POOL - 1)];
		if (pick < 7) begin
			send_request(3'($urandom_range(REQ_UNKNOWN_LAST)), {$urandom, $urandom},
				{$urandom, $urandom}, 5'($urandom_range(31)), 16'($urandom),
				4'($urandom));
			return;
		end
		if (pick < (fill_phase ? 55 : 30))
			code = REQ_ADD;
		else if (pick < (fill_phase ? 75 : 55))
			code = REQ_LOOKUP;
		else if (pick < (fill_phase ? 87 : 75))
			code = REQ_DEL_NAME;
		else if (pick < (fill_phase ? 96 : 90))
			code = REQ_DEL_HANDLE;
		else
			code = REQ_DEL_OWNER;
		send_request(code, lo, hi, drive_len, own, 4'($urandom_range(TABLE_ENTRIES - 1)));
	endtask

	initial begin
		logic [63:0] short_name;
		quiet = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		short_name = 64'h0000_0000_0000_6261;
		send_request(REQ_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 16'h0000, 4'd0);
		send_request(REQ_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 16'h0005, 4'd0);
		send_request(REQ_ADD, '1, '1, 5'd16, 16'hFFFF, 4'd0);
		send_request(REQ_LOOKUP, '1, '1, 5'd31, 16'h0000, 4'd0);
		send_request(REQ_ADD, short_name | 64'hA5A5_0000_0000_0000, '1, 5'd2, 16'h1234, 4'd0);
		send_request(REQ_LOOKUP, short_name | 64'h0000_FF00_0000_0000, '0, 5'd2, 16'h0000, 4'd0);
		send_request(REQ_LOOKUP, short_name, '0, 5'd3, 16'h0000, 4'd0);
		send_request(REQ_ADD, {$urandom, $urandom}, {$urandom, $urandom}, 5'd9, 16'h1234, 4'd0);
		send_request(REQ_DEL_HANDLE, '0, '0, 5'd0, 16'h0000, 4'd15);
		send_request(REQ_DEL_HANDLE, '0, '0, 5'd0, 16'h0000, 4'd1);
		send_request(REQ_DEL_NAME, short_name | 64'h1111_0000_0000_0000, '0, 5'd2, 16'h0000, 4'd0);
		send_request(REQ_UNKNOWN_LAST, '1, '1, 5'd31, 16'hFFFF, 4'd15);
		send_request(REQ_UNKNOWN_FIRST, {$urandom, $urandom}, {$urandom, $urandom}, 5'd7,
			16'h00FF, 4'd3);
		for (int i = 0; i < TABLE_ENTRIES - 1; i++)
			send_request(REQ_ADD, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | 64'(i), '0,
				5'd8, FILL_OWNER, 4'd0);
		send_request(REQ_DEL_OWNER, '0, '0, 5'd0, FILL_OWNER, 4'd0);

		owner_set[0] = 16'h0000;
		owner_set[1] = 16'hFFFF;
		for (int i = 2; i < OWNER_POOL; i++)
			owner_set[i] = 16'($urandom);
		for (int i = 0; i < NAME_POOL; i++) begin
			pool_lo[i] = {$urandom, $urandom};
			pool_hi[i] = {$urandom, $urandom};
			pool_len[i] = $urandom_range(NAME_BYTES);
			if (i > 0 && $urandom_range(3) == 0) begin
				pool_lo[i] = pool_lo[i - 1];
				pool_hi[i] = pool_hi[i - 1];
				pool_len[i] = (pool_len[i - 1] < NAME_BYTES) ? pool_len[i - 1] + 1
					: pool_len[i - 1] - 1;
			end
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 400 && i < 700);
			random_request((i / 120) % 2 == 0);
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (TABLE_ENTRIES + 4) @(negedge clk);

		$display("Sent %0d adds, %0d lookups, %0d name deletes, %0d handle deletes, %0d owner sweeps",
			sent_by_code[REQ_ADD], sent_by_code[REQ_LOOKUP], sent_by_code[REQ_DEL_NAME],
			sent_by_code[REQ_DEL_HANDLE], sent_by_code[REQ_DEL_OWNER]);
		$display("plus %0d unknown codes; %0d results compared with the mirrored table",
			sent_by_code[5] + sent_by_code[6] + sent_by_code[7], checked);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
